@@ rtl/core/pgs_pkg.sv @@
// Shared types and constants for the presentation-graphics segment parser.
package pgs_pkg;

  localparam int unsigned QueueDepth = 4;

  typedef enum logic [3:0] {
    KIND_HEADER    = 4'd0,
    KIND_PAL_HEAD  = 4'd1,
    KIND_PAL_ENTRY = 4'd2,
    KIND_IMG_HEAD  = 4'd3,
    KIND_IMG_BYTE  = 4'd4,
    KIND_WINDOW    = 4'd5,
    KIND_COMP      = 4'd6,
    KIND_OBJECT    = 4'd7,
    KIND_SEG_END   = 4'd8,
    KIND_ERROR     = 4'd9
  } kind_t;

  localparam logic [7:0] SEG_PALETTE = 8'h14;
  localparam logic [7:0] SEG_IMAGE   = 8'h15;
  localparam logic [7:0] SEG_COMP    = 8'h16;
  localparam logic [7:0] SEG_WINDOW  = 8'h17;
  localparam logic [7:0] SEG_END     = 8'h80;
  localparam logic [7:0] FPS_24      = 8'h10;
  localparam logic [7:0] MAGIC_P     = 8'h50;
  localparam logic [7:0] MAGIC_G     = 8'h47;

  localparam logic [7:0] ERR_MAGIC   = 8'd1;
  localparam logic [7:0] ERR_PALETTE = 8'd2;
  localparam logic [7:0] ERR_IMAGE   = 8'd3;
  localparam logic [7:0] ERR_WINDOW  = 8'd4;
  localparam logic [7:0] ERR_COMP    = 8'd5;
  localparam logic [7:0] ERR_END     = 8'd6;

  localparam logic [0:0] CFG_PASS_IMAGE = 1'b0;

  typedef struct packed {
    logic [3:0]  record_kind;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [15:0] ident;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] size_w;
    logic [15:0] size_h;
    logic [7:0]  byte_a;
    logic [7:0]  byte_b;
    logic [7:0]  byte_c;
  } record_t;

  // One step's work: up to two records.
  typedef struct packed {
    logic    two;
    record_t rec0;
    record_t rec1;
  } step_t;

endpackage

@@ rtl/core/pgs_if.sv @@
// Valid/ready channel interfaces for input bytes and output records.
interface pgs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  modport source (output valid, output byte_value, input ready);
  modport sink   (input valid, input byte_value, output ready);
endinterface

interface pgs_rec_if;
  logic             valid;
  logic             ready;
  pgs_pkg::record_t rec;
  modport source (output valid, output rec, input ready);
  modport sink   (input valid, input rec, output ready);
endinterface

@@ rtl/core/pgs_front.sv @@
// Front part: byte parser state machine producing up to two records per byte.
module pgs_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pass_image,
  input  logic           in_valid,
  input  logic [7:0]     in_byte,
  output logic           in_ready,
  output logic           push,
  output pgs_pkg::step_t push_data,
  input  logic           q_room
);

  typedef enum logic [3:0] {
    PH_HEADER, PH_PAL_HEAD, PH_PAL_ENTRY, PH_IMG_HEAD, PH_IMG_FIRST,
    PH_IMG_DATA, PH_WIN_COUNT, PH_WIN_ENTRY, PH_COMP_HEAD, PH_COMP_OBJ,
    PH_SKIP, PH_ERROR
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hidx_r, hidx_nxt;
  logic [31:0] pts_r, pts_nxt, dts_r, dts_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [15:0] left_r, left_nxt;
  logic [7:0]  recs_r, recs_nxt;
  logic [3:0]  ridx_r, ridx_nxt;
  logic [7:0]  rb_r [11];
  logic [7:0]  rb_nxt [11];
  logic [15:0] left_m1;
  logic [3:0]  ridx_p1, iend;
  logic        fire;
  int          n;
  pgs_pkg::record_t r [2];

  assign in_ready = q_room;
  assign fire     = in_valid && q_room;
  assign left_m1  = left_r - 16'd1;
  assign ridx_p1  = ridx_r + 4'd1;

  function automatic logic [15:0] be16(input logic [7:0] hi, input logic [7:0] lo);
    return {hi, lo};
  endfunction

  // (len-2) mod 5 by reciprocal multiplication; a subtract loop is too deep.
  function automatic logic hl_pal_bad(input logic [15:0] len);
    logic [15:0] m;
    logic [35:0] p;
    m = len - 16'd2;
    p = {20'd0, m} * 36'd52429;
    return (m - 16'(p[33:18] * 16'd5)) != 16'd0;
  endfunction

  always_comb begin
    unique case (phase_r)
      PH_PAL_HEAD:  iend = 4'd2;
      PH_PAL_ENTRY: iend = 4'd5;
      PH_IMG_HEAD:  iend = 4'd4;
      PH_IMG_FIRST: iend = 4'd11;
      PH_WIN_ENTRY: iend = 4'd9;
      PH_COMP_HEAD: iend = 4'd11;
      PH_COMP_OBJ:  iend = 4'd8;
      default:      iend = 4'd0;
    endcase
  end

  always_comb begin
    logic [7:0] rl;
    logic [15:0] hl;
    phase_nxt = phase_r; hidx_nxt = hidx_r; pts_nxt = pts_r; dts_nxt = dts_r;
    kind_nxt = kind_r; left_nxt = left_r; recs_nxt = recs_r; ridx_nxt = ridx_r;
    rl = 8'd0; hl = 16'd0;
    rb_nxt = rb_r;
    n = 0;
    r[0] = '0; r[1] = '0;
    if (fire) begin
      unique case (phase_r)
        PH_ERROR: ;
        PH_HEADER: begin
          if (hidx_r < 4'd2) rb_nxt[hidx_r] = in_byte;
          else if (hidx_r < 4'd6) pts_nxt = {pts_r[23:0], in_byte};
          else if (hidx_r < 4'd10) dts_nxt = {dts_r[23:0], in_byte};
          else if (hidx_r == 4'd10) kind_nxt = in_byte;
          else if (hidx_r == 4'd11) left_nxt = {in_byte, 8'd0};
          if (hidx_r < 4'd12) begin
            hidx_nxt = hidx_r + 4'd1;
          end else begin
            hidx_nxt = 4'd0;
            hl = {left_r[15:8], in_byte};
            left_nxt = hl;
            ridx_nxt = 4'd0;
            if (rb_r[0] != pgs_pkg::MAGIC_P || rb_r[1] != pgs_pkg::MAGIC_G) begin
              r[0].record_kind = pgs_pkg::KIND_ERROR;
              r[0].byte_a = pgs_pkg::ERR_MAGIC; n = 1; phase_nxt = PH_ERROR;
            end else begin
              r[0].record_kind = pgs_pkg::KIND_HEADER;
              r[0].word_a = pts_r; r[0].word_b = dts_r;
              r[0].ident = hl; r[0].byte_a = kind_r; n = 1;
              r[1].record_kind = pgs_pkg::KIND_ERROR;
              priority case (kind_r)
                pgs_pkg::SEG_PALETTE:
                  if (hl < 16'd2 || hl_pal_bad(hl)) begin
                    r[1].byte_a = pgs_pkg::ERR_PALETTE; n = 2; phase_nxt = PH_ERROR;
                  end else phase_nxt = PH_PAL_HEAD;
                pgs_pkg::SEG_IMAGE:
                  if (hl < 16'd4) begin
                    r[1].byte_a = pgs_pkg::ERR_IMAGE; n = 2; phase_nxt = PH_ERROR;
                  end else phase_nxt = PH_IMG_HEAD;
                pgs_pkg::SEG_COMP:
                  if (hl < 16'd11) begin
                    r[1].byte_a = pgs_pkg::ERR_COMP; n = 2; phase_nxt = PH_ERROR;
                  end else phase_nxt = PH_COMP_HEAD;
                pgs_pkg::SEG_WINDOW:
                  if (hl == 16'd0) begin
                    r[1].byte_a = pgs_pkg::ERR_WINDOW; n = 2; phase_nxt = PH_ERROR;
                  end else phase_nxt = PH_WIN_COUNT;
                pgs_pkg::SEG_END:
                  if (hl != 16'd0) begin
                    r[1].byte_a = pgs_pkg::ERR_END; n = 2; phase_nxt = PH_ERROR;
                  end else begin
                    r[1] = '0; r[1].record_kind = pgs_pkg::KIND_SEG_END; n = 2;
                    phase_nxt = PH_HEADER;
                  end
                default: phase_nxt = (hl == 16'd0) ? PH_HEADER : PH_SKIP;
              endcase
            end
          end
        end
        PH_IMG_DATA: begin
          if (pass_image) begin
            r[0].record_kind = pgs_pkg::KIND_IMG_BYTE;
            r[0].ident = be16(rb_r[0], rb_r[1]); r[0].byte_a = in_byte; n = 1;
          end
          left_nxt = left_m1;
          if (left_m1 == 16'd0) phase_nxt = PH_HEADER;
        end
        PH_SKIP: begin
          left_nxt = left_m1;
          if (left_m1 == 16'd0) phase_nxt = PH_HEADER;
        end
        PH_WIN_COUNT: begin
          left_nxt = left_m1;
          recs_nxt = in_byte;
          r[0].record_kind = pgs_pkg::KIND_ERROR; r[0].byte_a = pgs_pkg::ERR_WINDOW;
          if (in_byte != 8'd0) begin
            if (left_m1 < 16'd9) begin n = 1; phase_nxt = PH_ERROR; end
            else begin phase_nxt = PH_WIN_ENTRY; ridx_nxt = 4'd0; end
          end else if (left_m1 != 16'd0) begin
            n = 1; phase_nxt = PH_ERROR;
          end else phase_nxt = PH_HEADER;
        end
        default: begin
          if (ridx_r < 4'd11) rb_nxt[ridx_r] = in_byte;
          ridx_nxt = ridx_p1;
          left_nxt = left_m1;
          if (ridx_p1 >= iend) begin
            ridx_nxt = 4'd0;
            unique case (phase_r)
              PH_PAL_HEAD: begin
                r[0].record_kind = pgs_pkg::KIND_PAL_HEAD;
                r[0].ident = {8'd0, rb_nxt[0]}; r[0].byte_a = rb_nxt[1]; n = 1;
                phase_nxt = (left_m1 == 16'd0) ? PH_HEADER : PH_PAL_ENTRY;
              end
              PH_PAL_ENTRY: begin
                r[0].record_kind = pgs_pkg::KIND_PAL_ENTRY;
                r[0].ident = {8'd0, rb_nxt[0]};
                r[0].word_a = {8'd0, rb_nxt[1], rb_nxt[2], rb_nxt[3]};
                r[0].byte_a = rb_nxt[4]; n = 1;
                if (left_m1 == 16'd0) phase_nxt = PH_HEADER;
              end
              PH_IMG_HEAD, PH_IMG_FIRST: begin
                if (phase_r == PH_IMG_HEAD && rb_nxt[3][7]) begin
                  if (left_m1 < 16'd7) begin
                    r[0].record_kind = pgs_pkg::KIND_ERROR;
                    r[0].byte_a = pgs_pkg::ERR_IMAGE; n = 1; phase_nxt = PH_ERROR;
                  end else begin
                    // keep counting: the size header follows the 4-byte head
                    phase_nxt = PH_IMG_FIRST;
                    ridx_nxt = ridx_p1;
                  end
                end else begin
                  r[0].record_kind = pgs_pkg::KIND_IMG_HEAD;
                  r[0].ident = be16(rb_nxt[0], rb_nxt[1]);
                  r[0].byte_a = rb_nxt[2]; r[0].byte_b = rb_nxt[3]; n = 1;
                  if (phase_r == PH_IMG_FIRST) begin
                    r[0].word_a = {8'd0, rb_nxt[4], rb_nxt[5], rb_nxt[6]};
                    r[0].size_w = be16(rb_nxt[7], rb_nxt[8]);
                    r[0].size_h = be16(rb_nxt[9], rb_nxt[10]);
                  end
                  phase_nxt = (left_m1 == 16'd0) ? PH_HEADER : PH_IMG_DATA;
                end
              end
              PH_WIN_ENTRY, PH_COMP_HEAD, PH_COMP_OBJ: begin
                n = 1;
                if (phase_r == PH_WIN_ENTRY) begin
                  r[0].record_kind = pgs_pkg::KIND_WINDOW;
                  r[0].ident = {8'd0, rb_nxt[0]};
                  r[0].pos_x = be16(rb_nxt[1], rb_nxt[2]);
                  r[0].pos_y = be16(rb_nxt[3], rb_nxt[4]);
                  r[0].size_w = be16(rb_nxt[5], rb_nxt[6]);
                  r[0].size_h = be16(rb_nxt[7], rb_nxt[8]);
                  rl = recs_r - 8'd1;
                end else if (phase_r == PH_COMP_HEAD) begin
                  r[0].record_kind = pgs_pkg::KIND_COMP;
                  r[0].size_w = be16(rb_nxt[0], rb_nxt[1]);
                  r[0].size_h = be16(rb_nxt[2], rb_nxt[3]);
                  r[0].byte_b = (rb_nxt[4] == pgs_pkg::FPS_24) ? 8'd1 : 8'd0;
                  r[0].word_a = {16'd0, rb_nxt[5], rb_nxt[6]};
                  r[0].byte_a = rb_nxt[7]; r[0].pos_x = {8'd0, rb_nxt[8]};
                  r[0].byte_c = rb_nxt[9];
                  rl = rb_nxt[10];
                end else begin
                  r[0].record_kind = pgs_pkg::KIND_OBJECT;
                  r[0].ident = be16(rb_nxt[0], rb_nxt[1]);
                  r[0].byte_a = rb_nxt[2]; r[0].byte_b = rb_nxt[3];
                  r[0].pos_x = be16(rb_nxt[4], rb_nxt[5]);
                  r[0].pos_y = be16(rb_nxt[6], rb_nxt[7]);
                  rl = recs_r - 8'd1;
                end
                recs_nxt = rl;
                r[1].record_kind = pgs_pkg::KIND_ERROR;
                r[1].byte_a = (phase_r == PH_WIN_ENTRY) ? pgs_pkg::ERR_WINDOW
                                                        : pgs_pkg::ERR_COMP;
                if (rl != 8'd0) begin
                  if (left_m1 < ((phase_r == PH_WIN_ENTRY) ? 16'd9 : 16'd8)) begin
                    n = 2; phase_nxt = PH_ERROR;
                  end else phase_nxt = (phase_r == PH_WIN_ENTRY) ? PH_WIN_ENTRY
                                                                  : PH_COMP_OBJ;
                end else if (left_m1 != 16'd0) begin
                  n = 2; phase_nxt = PH_ERROR;
                end else phase_nxt = PH_HEADER;
              end
              default: ;
            endcase
          end
        end
      endcase
    end
  end

  assign push = fire && (n != 0);
  always_comb begin
    push_data.two  = (n == 2);
    push_data.rec0 = r[0];
    push_data.rec1 = r[1];
  end

  always_ff @(posedge clk) begin
    rb_r <= rb_nxt;
    if (!rst_n) begin
      phase_r <= PH_HEADER; hidx_r <= '0; pts_r <= '0; dts_r <= '0;
      kind_r <= '0; left_r <= '0; recs_r <= '0; ridx_r <= '0;
    end else begin
      phase_r <= phase_nxt; hidx_r <= hidx_nxt; pts_r <= pts_nxt; dts_r <= dts_nxt;
      kind_r <= kind_nxt; left_r <= left_nxt; recs_r <= recs_nxt; ridx_r <= ridx_nxt;
    end
  end

endmodule

@@ rtl/core/pgs_queue.sv @@
// Short queue of parsed steps between front and back parts.
module pgs_queue #(
  parameter int unsigned Depth = pgs_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pgs_pkg::step_t push_data,
  output logic           room,
  input  logic           pop,
  output logic           nonempty,
  output pgs_pkg::step_t head
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  pgs_pkg::step_t  mem_r [Depth];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r;

  assign room     = (cnt_r != (AW+1)'(Depth));
  assign nonempty = (cnt_r != '0);
  assign head     = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(Depth - 1)) ? '0 : wp_r + AW'(1);
      if (pop)  rp_r <= (rp_r == AW'(Depth - 1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

@@ rtl/core/pgs_back.sv @@
// Back part: issue one or two queued records through an output register.
module pgs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_nonempty,
  input  pgs_pkg::step_t    q_head,
  output logic              q_pop,
  output logic              out_valid,
  output pgs_pkg::record_t  out_rec,
  input  logic              out_ready
);
  logic             valid_r;
  pgs_pkg::record_t rec_r;
  logic             second_r;
  logic             load;

  // Load output register when empty or being drained.
  assign load  = q_nonempty && (!valid_r || out_ready);
  assign q_pop = load && (!q_head.two || second_r);
  assign out_valid = valid_r;
  assign out_rec   = rec_r;

  always_ff @(posedge clk) begin
    if (load) rec_r <= second_r ? q_head.rec1 : q_head.rec0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0; second_r <= 1'b0;
    end else begin
      if (load) valid_r <= 1'b1;
      else if (out_ready) valid_r <= 1'b0;
      if (load) second_r <= q_head.two && !second_r;
    end
  end
endmodule

@@ rtl/core/pgs_segment_stream_parser_top.sv @@
// Top level of the presentation-graphics segment stream parser.
// Throughput: one byte per cycle; a byte yielding two records issues them one after the other,
// and the input stalls while the step queue is full.
// An accepted byte's records are written to the step queue, then loaded into the output
// register that drives out_valid; that register holds its record until out_ready takes it.
// Reset (rst_n low, synchronous) returns to awaiting a header, clears the error,
// empties the queue and sets the image pass-through flag pass_r to 1.
module pgs_segment_stream_parser_top #(
  parameter int unsigned QueueDepth = pgs_pkg::QueueDepth
) (
  input  logic         clk,
  input  logic         rst_n,
  pgs_byte_if.sink     in_ch,
  pgs_rec_if.source    out_ch,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [0:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  logic           pass_r;
  logic           push, room, pop, nonempty;
  pgs_pkg::step_t push_data, head;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == pgs_pkg::CFG_PASS_IMAGE) ? {31'd0, pass_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) pass_r <= 1'b1;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == pgs_pkg::CFG_PASS_IMAGE)
      pass_r <= cfg_pwdata[0];
  end

  pgs_front u_front (
    .clk, .rst_n, .pass_image(pass_r),
    .in_valid(in_ch.valid), .in_byte(in_ch.byte_value), .in_ready(in_ch.ready),
    .push, .push_data, .q_room(room)
  );

  pgs_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst_n, .push, .push_data, .room, .pop, .nonempty, .head
  );

  pgs_back u_back (
    .clk, .rst_n, .q_nonempty(nonempty), .q_head(head), .q_pop(pop),
    .out_valid(out_ch.valid), .out_rec(out_ch.rec), .out_ready(out_ch.ready)
  );
endmodule

@@ rtl/core/pgs_checker.sv @@
// Port-level checker for the segment parser, bound to the top level.
module pgs_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input pgs_pkg::record_t out_rec,
  input logic             cfg_pready
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rec)) else $error("output dropped");
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rec.record_kind <= pgs_pkg::KIND_ERROR) else $error("bad kind");
  a_after_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_rec.record_kind == pgs_pkg::KIND_ERROR
    |=> !(out_valid && out_rec.record_kind == pgs_pkg::KIND_ERROR && $past(out_ready)
          && !$stable(out_rec))) else $error("two errors");
  a_ready: assert property (@(posedge clk) cfg_pready) else $error("pready low");
endmodule

bind pgs_segment_stream_parser_top pgs_checker u_chk (
  .clk, .rst_n, .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_rec(out_ch.rec), .cfg_pready
);

@@ tb/tb_pgs_segment_stream_parser_top.sv @@
// Testbench for the segment stream parser: random segment streams checked against a predictor.
`timescale 1ns / 1ps

module tb_pgs_segment_stream_parser_top;

  typedef enum logic [3:0] {
    P_HEADER, P_PAL_HEAD, P_PAL_ENTRY, P_IMG_HEAD, P_IMG_FIRST, P_IMG_DATA,
    P_WIN_COUNT, P_WIN_ENTRY, P_COMP_HEAD, P_COMP_OBJ, P_SKIP, P_ERROR
  } phase_t;

  typedef struct {
    logic [7:0]       b;
    int               n;   // -1: check against the predictor
    pgs_pkg::record_t r0;
    pgs_pkg::record_t r1;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [0:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  pgs_byte_if in_if ();
  pgs_rec_if  out_if ();

  pgs_segment_stream_parser_top uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // Parser model state
  logic       m_pass_img;
  phase_t     m_phase;
  logic [3:0] m_hidx;
  logic [31:0] m_pts, m_dts;
  logic [7:0] m_kind;
  logic [15:0] m_left;
  logic [7:0] m_recs;
  logic [3:0] m_ridx;
  logic [7:0] m_rb [11];
  logic       m_err;

  pgs_pkg::record_t step_recs[$];
  pgs_pkg::record_t record_q[$];
  logic [7:0] seg[$];
  row_t rows[$];
  int mismatches = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int hold_left = 0;

  function automatic logic [15:0] be16(int i);
    return {m_rb[i % 11], m_rb[(i + 1) % 11]};
  endfunction

  function automatic pgs_pkg::record_t blank(pgs_pkg::kind_t k);
    pgs_pkg::record_t r;
    r = '0;
    r.record_kind = k;
    return r;
  endfunction

  function automatic void raise_error(logic [7:0] code);
    pgs_pkg::record_t r;
    r = blank(pgs_pkg::KIND_ERROR);
    r.byte_a = code;
    step_recs = {step_recs, r};
    m_err = 1'b1;
    m_phase = P_ERROR;
  endfunction

  function automatic void next_entry(int need, phase_t ph, logic [7:0] code);
    if (m_recs > 0) begin
      if (m_left < need) raise_error(code);
      else begin
        m_phase = ph;
        m_ridx = 4'd0;
      end
    end else if (m_left > 0) begin
      raise_error(code);
    end else begin
      m_phase = P_HEADER;
    end
  endfunction

  function automatic void open_segment();
    m_ridx = 4'd0;
    case (m_kind)
      pgs_pkg::SEG_PALETTE: begin
        if (m_left < 2 || ((m_left - 16'd2) % 5) != 0) raise_error(pgs_pkg::ERR_PALETTE);
        else m_phase = P_PAL_HEAD;
      end
      pgs_pkg::SEG_IMAGE: begin
        if (m_left < 4) raise_error(pgs_pkg::ERR_IMAGE);
        else m_phase = P_IMG_HEAD;
      end
      pgs_pkg::SEG_COMP: begin
        if (m_left < 11) raise_error(pgs_pkg::ERR_COMP);
        else m_phase = P_COMP_HEAD;
      end
      pgs_pkg::SEG_WINDOW: begin
        if (m_left < 1) raise_error(pgs_pkg::ERR_WINDOW);
        else m_phase = P_WIN_COUNT;
      end
      pgs_pkg::SEG_END: begin
        if (m_left != 0) raise_error(pgs_pkg::ERR_END);
        else begin
          step_recs = {step_recs, blank(pgs_pkg::KIND_SEG_END)};
          m_phase = P_HEADER;
        end
      end
      default: m_phase = (m_left == 0) ? P_HEADER : P_SKIP;
    endcase
  endfunction

  function automatic void image_head(bit first);
    pgs_pkg::record_t r;
    r = blank(pgs_pkg::KIND_IMG_HEAD);
    r.ident = be16(0);
    r.byte_a = m_rb[2];
    r.byte_b = m_rb[3];
    if (first) begin
      r.word_a = {8'd0, m_rb[4], be16(5)};
      r.size_w = be16(7);
      r.size_h = be16(9);
    end
    step_recs = {step_recs, r};
  endfunction

  function automatic void close_item();
    pgs_pkg::record_t r;
    case (m_phase)
      P_PAL_HEAD: begin
        r = blank(pgs_pkg::KIND_PAL_HEAD);
        r.ident = {8'd0, m_rb[0]};
        r.byte_a = m_rb[1];
        step_recs = {step_recs, r};
        m_ridx = 4'd0;
        m_phase = (m_left == 0) ? P_HEADER : P_PAL_ENTRY;
      end
      P_PAL_ENTRY: begin
        r = blank(pgs_pkg::KIND_PAL_ENTRY);
        r.ident = {8'd0, m_rb[0]};
        r.word_a = {8'd0, m_rb[1], m_rb[2], m_rb[3]};
        r.byte_a = m_rb[4];
        step_recs = {step_recs, r};
        m_ridx = 4'd0;
        if (m_left == 0) m_phase = P_HEADER;
      end
      P_IMG_HEAD: begin
        if (m_rb[3][7]) begin
          if (m_left < 7) raise_error(pgs_pkg::ERR_IMAGE);
          else m_phase = P_IMG_FIRST;
        end else begin
          image_head(1'b0);
          m_phase = (m_left == 0) ? P_HEADER : P_IMG_DATA;
        end
      end
      P_IMG_FIRST: begin
        image_head(1'b1);
        m_phase = (m_left == 0) ? P_HEADER : P_IMG_DATA;
      end
      P_WIN_ENTRY: begin
        r = blank(pgs_pkg::KIND_WINDOW);
        r.ident = {8'd0, m_rb[0]};
        r.pos_x = be16(1);
        r.pos_y = be16(3);
        r.size_w = be16(5);
        r.size_h = be16(7);
        step_recs = {step_recs, r};
        m_recs = m_recs - 8'd1;
        next_entry(9, P_WIN_ENTRY, pgs_pkg::ERR_WINDOW);
      end
      P_COMP_HEAD: begin
        r = blank(pgs_pkg::KIND_COMP);
        r.size_w = be16(0);
        r.size_h = be16(2);
        r.byte_b = (m_rb[4] == pgs_pkg::FPS_24) ? 8'd1 : 8'd0;
        r.word_a = {16'd0, be16(5)};
        r.byte_a = m_rb[7];
        r.pos_x = {8'd0, m_rb[8]};
        r.byte_c = m_rb[9];
        step_recs = {step_recs, r};
        m_recs = m_rb[10];
        next_entry(8, P_COMP_OBJ, pgs_pkg::ERR_COMP);
      end
      P_COMP_OBJ: begin
        r = blank(pgs_pkg::KIND_OBJECT);
        r.ident = be16(0);
        r.byte_a = m_rb[2];
        r.byte_b = m_rb[3];
        r.pos_x = be16(4);
        r.pos_y = be16(6);
        step_recs = {step_recs, r};
        m_recs = m_recs - 8'd1;
        next_entry(8, P_COMP_OBJ, pgs_pkg::ERR_COMP);
      end
      default: ;
    endcase
  endfunction

  function automatic int item_len(phase_t ph);
    case (ph)
      P_PAL_HEAD:  return 2;
      P_PAL_ENTRY: return 5;
      P_IMG_HEAD:  return 4;
      P_IMG_FIRST: return 11;
      P_WIN_ENTRY: return 9;
      P_COMP_HEAD: return 11;
      P_COMP_OBJ:  return 8;
      default:     return 0;
    endcase
  endfunction

  // Advance the model by one byte; results land in step_recs.
  function automatic void parse_byte(logic [7:0] b);
    pgs_pkg::record_t r;
    step_recs.delete();
    if (m_err || m_phase == P_ERROR) return;
    case (m_phase)
      P_HEADER: begin
        if (m_hidx < 2) m_rb[m_hidx] = b;
        else if (m_hidx < 6) m_pts = {m_pts[23:0], b};
        else if (m_hidx < 10) m_dts = {m_dts[23:0], b};
        else if (m_hidx == 10) m_kind = b;
        else if (m_hidx == 11) m_left = {b, 8'd0};
        else m_left = m_left | {8'd0, b};
        if (m_hidx < 12) begin
          m_hidx = m_hidx + 4'd1;
        end else begin
          m_hidx = 4'd0;
          if (m_rb[0] != pgs_pkg::MAGIC_P || m_rb[1] != pgs_pkg::MAGIC_G) begin
            raise_error(pgs_pkg::ERR_MAGIC);
          end else begin
            r = blank(pgs_pkg::KIND_HEADER);
            r.word_a = m_pts;
            r.word_b = m_dts;
            r.ident = m_left;
            r.byte_a = m_kind;
            step_recs = {step_recs, r};
            open_segment();
          end
        end
      end
      P_IMG_DATA: begin
        if (m_pass_img) begin
          r = blank(pgs_pkg::KIND_IMG_BYTE);
          r.ident = be16(0);
          r.byte_a = b;
          step_recs = {step_recs, r};
        end
        m_left = m_left - 16'd1;
        if (m_left == 0) m_phase = P_HEADER;
      end
      P_SKIP: begin
        m_left = m_left - 16'd1;
        if (m_left == 0) m_phase = P_HEADER;
      end
      P_WIN_COUNT: begin
        m_left = m_left - 16'd1;
        m_recs = b;
        next_entry(9, P_WIN_ENTRY, pgs_pkg::ERR_WINDOW);
      end
      default: begin
        if (m_ridx < 11) m_rb[m_ridx] = b;
        m_ridx = m_ridx + 4'd1;
        m_left = m_left - 16'd1;
        if (m_ridx >= item_len(m_phase)) close_item();
      end
    endcase
  endfunction

  task automatic report(string what, pgs_pkg::record_t got, pgs_pkg::record_t want);
    mismatches++;
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
  endtask

  task automatic check_record(pgs_pkg::record_t got);
    pgs_pkg::record_t want;
    if (record_q.size() == 0) begin
      report("unexpected record", got, '0);
    end else begin
      want = record_q.pop_front();
      if (got.record_kind !== want.record_kind || got.word_a !== want.word_a ||
          got.word_b !== want.word_b || got.ident !== want.ident ||
          got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
          got.size_w !== want.size_w || got.size_h !== want.size_h ||
          got.byte_a !== want.byte_a || got.byte_b !== want.byte_b ||
          got.byte_c !== want.byte_c)
        report("field", got, want);
    end
  endtask

  // Record receiver with random stalls and one long hold-off on request
  initial begin
    bit take;
    pgs_pkg::record_t got;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      take = out_if.valid && out_if.ready;
      got = out_if.rec;
      @(posedge clk);
      if (take) check_record(got);
      if (hold_req && hold_left == 0) hold_left = 300;
      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) hold_req = 1'b0;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !(idle_on && $urandom_range(99) < 36);
      end
    end
  end

  // Offer one byte, hold it until accepted, then predict its records.
  task automatic send_byte(logic [7:0] b, int n, pgs_pkg::record_t r0,
                           pgs_pkg::record_t r1);
    bit acc;
    if (idle_on && $urandom_range(99) < 36) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.byte_value <= b;
    do begin
      @(negedge clk);
      acc = in_if.ready;
      @(posedge clk);
    end while (!acc);
    parse_byte(b);
    if (n < 0) begin
      foreach (step_recs[i]) record_q = {record_q, step_recs[i]};
    end else begin
      if (n > 0) record_q = {record_q, r0};
      if (n > 1) record_q = {record_q, r1};
    end
  endtask

  task automatic cfg_write(logic v);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= pgs_pkg::CFG_PASS_IMAGE;
    cfg_pwdata <= {31'd0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    m_pass_img = v;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (record_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_byte(logic [7:0] b);
    seg = {seg, b};
  endtask

  task automatic add_header(logic [7:0] kind, logic [15:0] len);
    add_byte(pgs_pkg::MAGIC_P);
    add_byte(pgs_pkg::MAGIC_G);
    repeat (8) add_byte(8'($urandom_range(255)));
    add_byte(kind);
    add_byte(len[15:8]);
    add_byte(len[7:0]);
  endtask

  task automatic add_random(int n);
    repeat (n) add_byte(8'($urandom_range(255)));
  endtask

  // Append one well-formed segment of random type and content.
  task automatic build_segment();
    int c, d;
    bit first;
    logic [7:0] kind, flags;
    case ($urandom_range(5))
      0: begin
        c = $urandom_range(3);
        add_header(pgs_pkg::SEG_PALETTE, 16'(2 + 5 * c));
        add_random(2 + 5 * c);
      end
      1: begin
        first = 1'($urandom_range(1));
        d = $urandom_range(6);
        flags = 8'($urandom_range(255));
        flags[7] = first;
        add_header(pgs_pkg::SEG_IMAGE, 16'(4 + d + (first ? 7 : 0)));
        add_random(3);
        add_byte(flags);
        add_random(d + (first ? 7 : 0));
      end
      2: begin
        c = $urandom_range(2);
        add_header(pgs_pkg::SEG_WINDOW, 16'(1 + 9 * c));
        add_byte(8'(c));
        add_random(9 * c);
      end
      3: begin
        c = $urandom_range(2);
        add_header(pgs_pkg::SEG_COMP, 16'(11 + 8 * c));
        add_random(4);
        add_byte($urandom_range(1) ? pgs_pkg::FPS_24 : 8'($urandom_range(255)));
        add_random(5);
        add_byte(8'(c));
        add_random(8 * c);
      end
      4: add_header(pgs_pkg::SEG_END, 16'd0);
      default: begin
        do kind = 8'($urandom_range(255));
        while (kind == pgs_pkg::SEG_PALETTE || kind == pgs_pkg::SEG_IMAGE ||
               kind == pgs_pkg::SEG_COMP || kind == pgs_pkg::SEG_WINDOW ||
               kind == pgs_pkg::SEG_END);
        d = $urandom_range(4);
        add_header(kind, 16'(d));
        add_random(d);
      end
    endcase
  endtask

  task automatic add_row(logic [7:0] b, int n, pgs_pkg::record_t r0,
                         pgs_pkg::record_t r1);
    row_t r;
    r.b = b;
    r.n = n;
    r.r0 = r0;
    r.r1 = r1;
    rows = {rows, r};
  endtask

  initial begin
    #2000000;
    $display("** pgs_segment_stream_parser_top: FAILED **");
    $finish;
  end

  initial begin
    pgs_pkg::record_t hdr;
    int sent;
    logic [7:0] pal [15];
    in_if.valid = 1'b0;
    in_if.byte_value = '0;
    m_pass_img = 1'b1;
    m_phase = P_HEADER;
    m_hidx = 4'd0;
    m_pts = '0;
    m_dts = '0;
    m_kind = '0;
    m_left = '0;
    m_recs = '0;
    m_ridx = 4'd0;
    foreach (m_rb[i]) m_rb[i] = '0;
    m_err = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // End segment with all-ones pts and zero dts: header plus segment end
    hdr = blank(pgs_pkg::KIND_HEADER);
    hdr.word_a = 32'hFFFF_FFFF;
    hdr.byte_a = pgs_pkg::SEG_END;
    add_row(pgs_pkg::MAGIC_P, 0, '0, '0);
    add_row(pgs_pkg::MAGIC_G, 0, '0, '0);
    repeat (4) add_row(8'hFF, 0, '0, '0);
    repeat (4) add_row(8'h00, 0, '0, '0);
    add_row(pgs_pkg::SEG_END, 0, '0, '0);
    add_row(8'h00, 0, '0, '0);
    add_row(8'h00, 2, hdr, blank(pgs_pkg::KIND_SEG_END));
    // Empty palette, then a zero-length unknown segment
    pal = '{pgs_pkg::MAGIC_P, pgs_pkg::MAGIC_G, 8'h00, 8'h00, 8'h00, 8'h01, 8'h80, 8'h00,
            8'h00, 8'h00, pgs_pkg::SEG_PALETTE, 8'h00, 8'h02, 8'hFF, 8'h00};
    foreach (pal[i]) add_row(pal[i], -1, '0, '0);
    foreach (rows[i]) send_byte(rows[i].b, rows[i].n, rows[i].r0, rows[i].r1);
    add_header(8'h00, 16'd0);
    foreach (seg[i]) send_byte(seg[i], -1, '0, '0);
    seg.delete();
    drain();

    for (int p = 0; p < 4; p++) begin
      cfg_write(p == 0 ? 1'b0 : (p == 1 ? 1'b1 : 1'($urandom_range(1))));
      idle_on = (p != 1);
      sent = 0;
      while (sent < 100) begin
        build_segment();
        if (p == 1 && sent == 0) hold_req = 1'b1;
        foreach (seg[i]) send_byte(seg[i], -1, '0, '0);
        sent += seg.size();
        seg.delete();
      end
      drain();
    end

    // One malformed segment at the end; the error is sticky, later bytes are ignored
    case ($urandom_range(1, 6))
      1: begin
        add_header(8'h00, 16'd0);
        seg[0] = 8'h00;
      end
      2: add_header(pgs_pkg::SEG_PALETTE, 16'd3);
      3: add_header(pgs_pkg::SEG_IMAGE, 16'd2);
      4: add_header(pgs_pkg::SEG_WINDOW, 16'd0);
      5: add_header(pgs_pkg::SEG_COMP, 16'd5);
      default: add_header(pgs_pkg::SEG_END, 16'd1);
    endcase
    add_random(12);
    foreach (seg[i]) send_byte(seg[i], -1, '0, '0);
    seg.delete();
    drain();
    repeat (10) @(posedge clk);

    if (mismatches == 0 && record_q.size() == 0) begin
      $display("** pgs_segment_stream_parser_top: PASSED **");
    end else begin
      $display("** pgs_segment_stream_parser_top: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/pgs_pkg.sv
rtl/core/pgs_if.sv
rtl/core/pgs_front.sv
rtl/core/pgs_queue.sv
rtl/core/pgs_back.sv
rtl/core/pgs_segment_stream_parser_top.sv
rtl/core/pgs_checker.sv
tb/tb_pgs_segment_stream_parser_top.sv
